@@ sv/teq_pkg.sv @@
// Shared types, constants and status codes of the timed event queue.
package teq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int MAX_RESULTS  = 16;
	localparam int NW           = $clog2(MAX_RESULTS);

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [2:0] ST_ADDED = 3'd0;
	localparam logic [2:0] ST_DUP   = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_FIRE  = 3'd3;
	localparam logic [2:0] ST_NONE  = 3'd4;

	localparam logic [1:0] SH_ROTATE = 2'd0;
	localparam logic [1:0] SH_INSERT = 2'd1;
	localparam logic [1:0] SH_POP    = 2'd2;

	typedef struct packed {
		logic       load_req;
		logic       walk_start;
		logic       shift;
		logic [1:0] mode;
		logic       cnt_inc;
		logic       out_load;
		logic [2:0] out_status;
		logic       out_last;
	} teq_cmd_t;

	typedef struct packed {
		logic req_add;
		logic dup;
		logic full;
		logic head_due;
		logic next_due;
		logic out_free;
	} teq_stat_t;

endpackage

@@ sv/timed_event_queue.sv @@
// Top level of the timed event queue: controller and datapath joined by command and status.
//
// The block keeps up to CAPACITY pending fire events sorted by fire time in a shift line of
// entry registers. An add transaction (req_type 0) produces exactly one result: added,
// duplicate rejected (the same slat and cue pair is already queued, checked before the full
// test), or queue full. A new event goes behind every queued event with the same or an earlier
// time. A tick transaction (req_type 1) carries the current time and pops, head first, every
// event whose time is at or before it, one fire result per event with its slat and cue, at most
// 16 per tick; later due events stay queued for the next tick. When nothing is due, a tick gives
// a single nothing-due result. The last result of each transaction has last set, and pending
// always shows the queue depth after that result. fire_slat and fire_cue read zero unless the
// status is fire. An add that is stored takes two full rotations of the entry line, one entry per
// cycle: the first looks for a duplicate and the second merges the new event into place. A
// rejected add (duplicate or full) answers after the first rotation. A tick, once accepted,
// gives its results in turn, each fire popping the head of the line in a single shift; each
// result waits for the output register to be free. A new transaction is taken only once the
// previous one has produced all its results; a result waiting in the output register does
// not hold up the next one.
module timed_event_queue import teq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [31:0] event_time,
	input  logic [7:0]  slat_in,
	input  logic [7:0]  cue_in,
	input  logic [31:0] current_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  fire_slat,
	output logic [7:0]  fire_cue,
	output logic        last,
	output logic [4:0]  pending
);

	// Commands from the sequencer and the flags it steers by.
	teq_cmd_t  cmd;
	teq_stat_t stat;

	teq_controller #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.stat    (stat),
		.cmd     (cmd)
	);

	// The datapath captures the request on acceptance and owns the entry line,
	// the queue count and the output register.
	teq_datapath #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (req_type),
		.event_time  (event_time),
		.slat_in     (slat_in),
		.cue_in      (cue_in),
		.current_time(current_time),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.status      (status),
		.fire_slat   (fire_slat),
		.fire_cue    (fire_cue),
		.last        (last),
		.pending     (pending)
	);

endmodule

@@ sv/teq_datapath.sv @@
// Datapath of the timed event queue: entry shift line, request and result registers.
module teq_datapath import teq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_type,
	input  logic [31:0] event_time,
	input  logic [7:0]  slat_in,
	input  logic [7:0]  cue_in,
	input  logic [31:0] current_time,
	input  teq_cmd_t    cmd,
	output teq_stat_t   stat,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [2:0]  status,
	output logic [7:0]  fire_slat,
	output logic [7:0]  fire_cue,
	output logic        last,
	output logic [4:0]  pending
);

	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int NXT = (CAPACITY > 1) ? 1 : 0;

	logic          req_type_q;
	logic [31:0]   ev_time_q;
	logic [7:0]    slat_q;
	logic [7:0]    cue_q;
	logic [31:0]   now_q;

	logic [31:0]   ent_time_q [CAPACITY];
	logic [7:0]    ent_slat_q [CAPACITY];
	logic [7:0]    ent_cue_q  [CAPACITY];
	logic [31:0]   carry_time_q;
	logic [7:0]    carry_slat_q;
	logic [7:0]    carry_cue_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;
	logic          dup_q;
	logic          ins_q;
	logic          out_valid_q;

	logic          head_live;
	logic          head_match;
	logic          place_new;
	logic          popping;
	logic [31:0]   tail_time;
	logic [7:0]    tail_slat;
	logic [7:0]    tail_cue;
	logic [CW-1:0] cnt_after;
	logic [CW+4:0] cnt_wide;

	assign head_live  = (rem_q != '0);
	assign head_match = (ent_slat_q[0] == slat_q) && (ent_cue_q[0] == cue_q);
	assign place_new  = !ins_q && (!head_live || (ev_time_q < ent_time_q[0]));
	assign popping    = cmd.shift && (cmd.mode == SH_POP);
	assign cnt_after  = popping ? (count_q - CW'(1)) : count_q;
	assign cnt_wide   = (CW + 5)'(cnt_after);

	always_comb begin
		tail_time = ent_time_q[0];
		tail_slat = ent_slat_q[0];
		tail_cue  = ent_cue_q[0];
		case (cmd.mode)
			SH_INSERT: begin
				if (ins_q) begin
					tail_time = carry_time_q;
					tail_slat = carry_slat_q;
					tail_cue  = carry_cue_q;
				end else if (place_new) begin
					tail_time = ev_time_q;
					tail_slat = slat_q;
					tail_cue  = cue_q;
				end
			end
			default: begin
				tail_time = ent_time_q[0];
				tail_slat = ent_slat_q[0];
				tail_cue  = ent_cue_q[0];
			end
		endcase
	end

	always_comb begin
		stat.req_add  = (req_type_q == REQ_ADD);
		stat.dup      = dup_q;
		stat.full     = (count_q >= CW'(CAPACITY));
		stat.head_due = (count_q != '0) && (now_q >= ent_time_q[0]);
		stat.next_due = (count_q > CW'(1)) && (now_q >= ent_time_q[NXT]);
		stat.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_type_q <= req_type;
			ev_time_q  <= event_time;
			slat_q     <= slat_in;
			cue_q      <= cue_in;
			now_q      <= current_time;
		end
	end

	// One place per cycle toward the head while shift is set; the freed tail takes the selected entry.
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				ent_time_q[i] <= ent_time_q[i + 1];
				ent_slat_q[i] <= ent_slat_q[i + 1];
				ent_cue_q[i]  <= ent_cue_q[i + 1];
			end
			ent_time_q[CAPACITY - 1] <= tail_time;
			ent_slat_q[CAPACITY - 1] <= tail_slat;
			ent_cue_q[CAPACITY - 1]  <= tail_cue;
			if ((cmd.mode == SH_INSERT) && (ins_q || place_new)) begin
				carry_time_q <= ent_time_q[0];
				carry_slat_q <= ent_slat_q[0];
				carry_cue_q  <= ent_cue_q[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q   <= '0;
			dup_q   <= 1'b0;
			ins_q   <= 1'b0;
		end else begin
			if (cmd.walk_start) begin
				rem_q <= count_q;
				dup_q <= 1'b0;
				ins_q <= 1'b0;
			end else if (cmd.shift) begin
				if (head_live) begin
					rem_q <= rem_q - CW'(1);
				end
				if ((cmd.mode == SH_ROTATE) && head_live && head_match) begin
					dup_q <= 1'b1;
				end
				if ((cmd.mode == SH_INSERT) && place_new) begin
					ins_q <= 1'b1;
				end
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (popping) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status  <= cmd.out_status;
			last    <= cmd.out_last;
			pending <= cnt_wide[4:0];
			if (cmd.out_status == ST_FIRE) begin
				fire_slat <= ent_slat_q[0];
				fire_cue  <= ent_cue_q[0];
			end else begin
				fire_slat <= '0;
				fire_cue  <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/teq_controller.sv @@
// Controller of the timed event queue: sequences the walks over the entries.
module teq_controller import teq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      req_type,
	input  teq_stat_t stat,
	output teq_cmd_t  cmd
);

	localparam int KW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DUP    = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_INS    = 3'd3;
	localparam logic [2:0] S_ADDED  = 3'd4;
	localparam logic [2:0] S_TICK   = 3'd5;

	logic [2:0]    state_q, state_d;
	logic [KW-1:0] k_q, k_d;
	logic [NW-1:0] n_q, n_d;
	logic          fire_last;

	assign fire_last = (n_q == NW'(MAX_RESULTS - 1)) || !stat.next_due;

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		n_d      = n_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.mode = SH_ROTATE;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req   = 1'b1;
					cmd.walk_start = 1'b1;
					k_d            = '0;
					n_d            = '0;
					state_d        = (req_type == REQ_ADD) ? S_DUP : S_TICK;
				end
			end
			S_DUP: begin
				cmd.shift = 1'b1;
				cmd.mode  = SH_ROTATE;
				if (k_q == KW'(CAPACITY - 1)) begin
					state_d = S_DECIDE;
				end else begin
					k_d = k_q + KW'(1);
				end
			end
			S_DECIDE: begin
				if (stat.out_free) begin
					if (stat.dup || stat.full) begin
						cmd.out_load   = 1'b1;
						cmd.out_status = stat.dup ? ST_DUP : ST_FULL;
						cmd.out_last   = 1'b1;
						state_d        = S_IDLE;
					end else begin
						cmd.walk_start = 1'b1;
						k_d            = '0;
						state_d        = S_INS;
					end
				end
			end
			S_INS: begin
				cmd.shift = 1'b1;
				cmd.mode  = SH_INSERT;
				if (k_q == KW'(CAPACITY - 1)) begin
					cmd.cnt_inc = 1'b1;
					state_d     = S_ADDED;
				end else begin
					k_d = k_q + KW'(1);
				end
			end
			S_ADDED: begin
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = ST_ADDED;
					cmd.out_last   = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_TICK: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (stat.head_due) begin
						cmd.out_status = ST_FIRE;
						cmd.out_last   = fire_last;
						cmd.shift      = 1'b1;
						cmd.mode       = SH_POP;
						n_d            = n_q + NW'(1);
						if (fire_last) begin
							state_d = S_IDLE;
						end
					end else begin
						cmd.out_status = ST_NONE;
						cmd.out_last   = 1'b1;
						state_d        = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			n_q     <= n_d;
		end
	end

endmodule

@@ sv/teq_checker.sv @@
// Port-level checks of the timed event queue and their binding to the top level.
module teq_checker import teq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        req_type,
	input logic [31:0] event_time,
	input logic [7:0]  slat_in,
	input logic [7:0]  cue_in,
	input logic [31:0] current_time,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [7:0]  fire_slat,
	input logic [7:0]  fire_cue,
	input logic        last,
	input logic [4:0]  pending
);

	// A stalled result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pending)
		&& $stable(fire_slat) && $stable(fire_cue) && $stable(last))
		else $error("result changed while stalled");

	// Only a fire result carries a slat and cue.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_FIRE) |-> (fire_slat == 8'd0) && (fire_cue == 8'd0))
		else $error("slat or cue set on a non-fire result");

	// Every status other than fire ends its transaction.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_FIRE) |-> last)
		else $error("non-fire result without last");

	// After a successful add the queue cannot be empty.
	a_added_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ADDED) |-> (pending != 5'd0))
		else $error("added result with empty queue");

	// No new transaction is taken while one is still producing results.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |-> !in_ready)
		else $error("input taken in the middle of a tick");

endmodule

bind timed_event_queue teq_checker u_teq_checker (.*);
